// ===== rtl/spbfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spbfs_pkg;

  localparam int STATE_COUNT     = 362880;
  localparam int CELLS           = 9;
  localparam int TILE_W          = 4;
  localparam int DEPTH_W         = 5;
  localparam int RANK_W          = 19;
  localparam int VIS_W           = 32;
  localparam int VIS_SHIFT       = 5;
  localparam int VIS_ROWS        = (STATE_COUNT + VIS_W - 1) / VIS_W;
  localparam int VIS_AW          = $clog2(VIS_ROWS);
  localparam int QUEUE_DEPTH_DEF = 65536;
  localparam int ENTRY_W         = CELLS * TILE_W + TILE_W + DEPTH_W;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 8;

  typedef logic [CELLS-1:0][TILE_W-1:0] board_t;
  typedef logic [CELLS-1:0][TILE_W-1:0] digits_t;

  // classified board handed from front to back
  typedef struct packed {
    board_t            tiles;
    logic [TILE_W-1:0] blank;
    logic              bad;
  } job_t;

  typedef enum logic [1:0] {
    MOVE_UP    = 2'd0,
    MOVE_RIGHT = 2'd1,
    MOVE_DOWN  = 2'd2,
    MOVE_LEFT  = 2'd3
  } move_t;

  // goal board: cell 0 holds 8 down to cell 8 holding the blank
  localparam board_t GOAL_BOARD =
    {4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};

  function automatic logic [15:0] fact(input int n);
    logic [15:0] f;
    case (n)
      0, 1:    f = 16'd1;
      2:       f = 16'd2;
      3:       f = 16'd6;
      4:       f = 16'd24;
      5:       f = 16'd120;
      6:       f = 16'd720;
      7:       f = 16'd5040;
      8:       f = 16'd40320;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  // count of smaller tiles to the right of each cell
  function automatic digits_t rank_digits(input board_t b);
    digits_t d;
    d = '0;
    for (int i = 0; i < CELLS; i++) begin
      for (int j = 0; j < CELLS; j++) begin
        if (j > i && b[j] < b[i]) d[i] = d[i] + 4'd1;
      end
    end
    return d;
  endfunction

  // weighted digit sum over cells lo..hi
  function automatic logic [RANK_W-1:0] rank_part(input digits_t d, input int lo,
                                                  input int hi);
    logic [RANK_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (i >= lo && i <= hi)
        acc = acc + RANK_W'(d[i]) * RANK_W'(fact(CELLS - 1 - i));
    end
    return acc;
  endfunction

  function automatic logic [1:0] col_of(input logic [TILE_W-1:0] p);
    logic [1:0] c;
    case (p)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic move_ok(input move_t k, input logic [TILE_W-1:0] p);
    logic ok;
    case (k)
      MOVE_UP:    ok = (p >= 4'd3);
      MOVE_RIGHT: ok = (col_of(p) != 2'd2);
      MOVE_DOWN:  ok = (p <= 4'd5);
      MOVE_LEFT:  ok = (col_of(p) != 2'd0);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [TILE_W-1:0] move_cell(input move_t k,
                                                  input logic [TILE_W-1:0] p);
    logic [TILE_W-1:0] q;
    case (k)
      MOVE_UP:    q = p - 4'd3;
      MOVE_RIGHT: q = p + 4'd1;
      MOVE_DOWN:  q = p + 4'd3;
      MOVE_LEFT:  q = p - 4'd1;
      default:    q = p;
    endcase
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spbfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spbfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/spbfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spbfs_front import spbfs_pkg::*; (
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire board_t in_tiles,
  output logic        job_valid,
  input  wire logic   job_ready,
  output job_t        job
);

  logic              bad;
  logic [TILE_W-1:0] blank;

  // flag tiles out of range or repeated, find the blank
  always_comb begin
    bad   = 1'b0;
    blank = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (in_tiles[i] > 4'd8) bad = 1'b1;
      for (int j = 0; j < CELLS; j++) begin
        if (j < i && in_tiles[j] == in_tiles[i]) bad = 1'b1;
      end
      if (in_tiles[i] == 4'd0) blank = TILE_W'(i);
    end
  end

  assign job.tiles = in_tiles;
  assign job.blank = blank;
  assign job.bad   = bad;
  assign job_valid = in_valid;
  assign in_ready  = job_ready;

endmodule
`default_nettype wire

// ===== rtl/spbfs_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spbfs_jobq import spbfs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // two-entry queue between front and search
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_job;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spbfs_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spbfs_search import spbfs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire job_t               job,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [DEPTH_W-1:0]      res_move_count,
  output logic                    res_reachable,
  output logic                    res_bad_input
);

  localparam int QA = $clog2(QUEUE_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLEAR  = 11'b00000000010,
    S_RDIG   = 11'b00000000100,
    S_RSUM   = 11'b00000001000,
    S_RADD   = 11'b00000010000,
    S_VREAD  = 11'b00000100000,
    S_VCHECK = 11'b00001000000,
    S_POP    = 11'b00010000000,
    S_PWAIT  = 11'b00100000000,
    S_NEIGH  = 11'b01000000000,
    S_FINISH = 11'b10000000000
  } state_t;

  state_t              state;
  board_t              cur;
  logic [TILE_W-1:0]   cur_blank;
  logic [DEPTH_W-1:0]  cur_depth;
  board_t              nb;
  logic [TILE_W-1:0]   nb_blank;
  logic [DEPTH_W-1:0]  nb_depth;
  digits_t             digits;
  logic [RANK_W-1:0]   rank_hi;
  logic [RANK_W-1:0]   rank_lo;
  logic [RANK_W-1:0]   rank;
  move_t               k;
  logic                seeding;
  logic [VIS_AW-1:0]   clr_addr;
  logic [QA-1:0]       head;
  logic [QA-1:0]       tail;
  logic [QA:0]         count;
  logic [DEPTH_W-1:0]  fin_move;
  logic                fin_reach;
  logic                fin_bad;

  logic                vis_we;
  logic [VIS_AW-1:0]   vis_addr;
  logic [VIS_W-1:0]    vis_wdata;
  logic [VIS_W-1:0]    vis_rdata;
  logic                q_we;
  logic [QA-1:0]       q_addr;
  logic [ENTRY_W-1:0]  q_wdata;
  logic [ENTRY_W-1:0]  q_rdata;

  logic [VIS_AW-1:0]   rank_row;
  logic                was_seen;
  logic                q_room;
  logic [QA-1:0]       head_next;
  logic [QA-1:0]       tail_next;
  board_t              pop_board;
  logic [TILE_W-1:0]   q_cell;
  board_t              swapped;

  assign rank_row  = VIS_AW'(rank >> VIS_SHIFT);
  assign was_seen  = vis_rdata[rank[VIS_SHIFT-1:0]];
  assign q_room    = (count < (QA+1)'(QUEUE_DEPTH));
  assign head_next = (head == QA'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == QA'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign pop_board = q_rdata[CELLS*TILE_W-1:0];
  assign q_cell    = move_cell(k, cur_blank);
  assign job_ready = (state == S_IDLE);

  // slide the tile at the target cell into the blank
  always_comb begin
    swapped            = cur;
    swapped[cur_blank] = cur[q_cell];
    swapped[q_cell]    = '0;
  end

  // memory port control
  always_comb begin
    vis_we    = 1'b0;
    vis_addr  = rank_row;
    vis_wdata = vis_rdata | (VIS_W'(1) << rank[VIS_SHIFT-1:0]);
    q_we      = 1'b0;
    q_addr    = head;
    q_wdata   = {nb_depth, nb_blank, nb};
    case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_addr  = clr_addr;
        vis_wdata = '0;
      end
      S_VCHECK: begin
        vis_we = !was_seen;
        q_we   = !was_seen && q_room;
        q_addr = tail;
      end
      default: ;
    endcase
  end

  spbfs_ram #(.WIDTH(VIS_W), .DEPTH(VIS_ROWS)) u_visited (
    .clk  (clk),
    .we   (vis_we),
    .addr (vis_addr),
    .wdata(vis_wdata),
    .rdata(vis_rdata)
  );

  spbfs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_frontier (
    .clk  (clk),
    .we   (q_we),
    .addr (q_addr),
    .wdata(q_wdata),
    .rdata(q_rdata)
  );

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      seeding   <= 1'b0;
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      clr_addr  <= '0;
      k         <= MOVE_UP;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            fin_move  <= '0;
            fin_reach <= 1'b0;
            fin_bad   <= job.bad;
            nb        <= job.tiles;
            nb_blank  <= job.blank;
            nb_depth  <= '0;
            seeding   <= 1'b1;
            clr_addr  <= '0;
            head      <= '0;
            tail      <= '0;
            count     <= '0;
            state     <= job.bad ? S_FINISH : S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VIS_AW'(VIS_ROWS - 1)) state <= S_RDIG;
        end
        S_RDIG: begin
          digits <= rank_digits(nb);
          state  <= S_RSUM;
        end
        S_RSUM: begin
          rank_hi <= rank_part(digits, 0, 3);
          rank_lo <= rank_part(digits, 4, CELLS - 1);
          state   <= S_RADD;
        end
        S_RADD: begin
          rank  <= rank_hi + rank_lo;
          state <= S_VREAD;
        end
        S_VREAD: state <= S_VCHECK;
        S_VCHECK: begin
          if (!was_seen && q_room) begin
            tail  <= tail_next;
            count <= count + 1'b1;
          end
          if (seeding) begin
            seeding <= 1'b0;
            state   <= S_POP;
          end else if (k == MOVE_LEFT) begin
            state <= S_POP;
          end else begin
            k     <= move_t'(k + 2'd1);
            state <= S_NEIGH;
          end
        end
        S_POP: begin
          if (count == '0) state <= S_FINISH;
          else             state <= S_PWAIT;
        end
        S_PWAIT: begin
          cur       <= pop_board;
          cur_blank <= q_rdata[CELLS*TILE_W +: TILE_W];
          cur_depth <= q_rdata[CELLS*TILE_W+TILE_W +: DEPTH_W];
          head      <= head_next;
          count     <= count - 1'b1;
          k         <= MOVE_UP;
          if (pop_board == GOAL_BOARD) begin
            fin_move  <= q_rdata[CELLS*TILE_W+TILE_W +: DEPTH_W];
            fin_reach <= 1'b1;
            state     <= S_FINISH;
          end else begin
            state <= S_NEIGH;
          end
        end
        S_NEIGH: begin
          if (move_ok(k, cur_blank)) begin
            nb       <= swapped;
            nb_blank <= q_cell;
            nb_depth <= cur_depth + 1'b1;
            state    <= S_RDIG;
          end else if (k == MOVE_LEFT) begin
            state <= S_POP;
          end else begin
            k <= move_t'(k + 2'd1);
          end
        end
        S_FINISH: begin
          if (!res_valid) begin
            res_valid      <= 1'b1;
            res_move_count <= fin_move;
            res_reachable  <= fin_reach;
            res_bad_input  <= fin_bad;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_puzzle_bfs_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Width  Contents
// s_axis    in   40     one board, nine 4-bit tiles
// m_axis    out  8      move count, reachable, bad input
//
// A bad board goes straight to the result. Any other board first clears the
// visited bitmap, one 32-bit row per cycle, then runs the search: each
// dequeued board is read from the frontier, then each move is tried in turn,
// and a legal neighbor is ranked, marked and queued if new and there is room;
// one neighbor rank is checked against the bitmap at a time.
// Reset is synchronous; a new board is taken while a result waits, and a
// stalled m_axis holds its word while the search goes on.
module sliding_puzzle_bfs_distance import spbfs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tile_at_0 [3:0] .. tile_at_8 [35:32], zero pad [39:36]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // move_count [4:0], reachable [5], bad_input [6], zero pad [7]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic               fr_valid;
  logic               fr_ready;
  job_t               fr_job;
  logic               jq_valid;
  logic               jq_ready;
  job_t               jq_job;
  logic [DEPTH_W-1:0] move_count;
  logic               reachable;
  logic               bad_input;

  spbfs_front u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_tiles (s_axis_tdata[CELLS*TILE_W-1:0]),
    .job_valid(fr_valid),
    .job_ready(fr_ready),
    .job      (fr_job)
  );

  spbfs_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_job  (fr_job),
    .pop_valid (jq_valid),
    .pop_ready (jq_ready),
    .pop_job   (jq_job)
  );

  spbfs_search #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_search (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (jq_valid),
    .job_ready     (jq_ready),
    .job           (jq_job),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res_move_count(move_count),
    .res_reachable (reachable),
    .res_bad_input (bad_input)
  );

  assign m_axis_tdata = {1'b0, bad_input, reachable, move_count};

endmodule
`default_nettype wire

// ===== rtl/spbfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spbfs_checker import spbfs_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word right after reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under stall");

  // bad board carries no distance and no reachable flag
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] == 6'd0)
    else $error("bad board reported a distance");

  // unreachable goal carries zero moves
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[4:0] == 5'd0)
    else $error("unreachable goal with nonzero moves");

endmodule

bind sliding_puzzle_bfs_distance spbfs_checker u_checker (.*);
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import spbfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000000;
  localparam int RING_DEPTH     = 65536;
  localparam int GOAL_RANK      = STATE_COUNT - 1;

  typedef logic [3:0] tiles_t [9];

  typedef struct packed {
    logic [4:0] move_count;
    logic       reachable;
    logic       bad_input;
  } verdict_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tile_at_0 [3:0] .. tile_at_8 [35:32], zero pad [39:36]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // move_count [4:0], reachable [5], bad_input [6], zero pad [7]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  verdict_t verdict_q[$];
  int       mismatch_count;
  int       boards_sent;
  int       words_checked;
  int       solved_seen;
  int       parity_seen;
  int       bad_seen;
  int       idle_pct;
  int       stall_pct;
  int       quiet_cycles;

  // search scratch for the predictor
  bit          visited[STATE_COUNT];
  logic [35:0] ring_tiles[RING_DEPTH];
  logic [3:0]  ring_blank[RING_DEPTH];
  logic [4:0]  ring_depth[RING_DEPTH];

  sliding_puzzle_bfs_distance uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int fact_weight(input int n);
    int f;
    f = 1;
    for (int i = 2; i <= n; i++) f *= i;
    return f;
  endfunction

  // Cantor rank of a board, 0-based
  function automatic int board_rank(input tiles_t b);
    int r;
    int n;
    r = 0;
    for (int i = 0; i < 9; i++) begin
      n = 0;
      for (int j = i + 1; j < 9; j++) if (b[j] < b[i]) n++;
      r += n * fact_weight(8 - i);
    end
    return r;
  endfunction

  function automatic logic [35:0] flatten(input tiles_t b);
    logic [35:0] v;
    for (int i = 0; i < 9; i++) v[4*i +: 4] = b[i];
    return v;
  endfunction

  // breadth-first distance to the descending goal
  function verdict_t fewest_moves(input tiles_t b);
    verdict_t    v;
    logic [8:0]  present;
    int          blank;
    int          head;
    int          tail;
    int          fill;
    int          p;
    int          q;
    int          r;
    logic [4:0]  d;
    tiles_t      s;
    tiles_t      n;
    v = '0;
    present = '0;
    blank = 0;
    for (int i = 0; i < 9; i++) begin
      if (b[i] > 8 || present[b[i]]) v.bad_input = 1'b1;
      else present[b[i]] = 1'b1;
      if (b[i] == 0) blank = i;
    end
    if (v.bad_input) return v;
    foreach (visited[i]) visited[i] = 1'b0;
    head = 0;
    tail = 1;
    fill = 1;
    visited[board_rank(b)] = 1'b1;
    ring_tiles[0] = flatten(b);
    ring_blank[0] = blank[3:0];
    ring_depth[0] = '0;
    while (fill != 0) begin
      for (int i = 0; i < 9; i++) s[i] = ring_tiles[head][4*i +: 4];
      p = ring_blank[head];
      d = ring_depth[head];
      head = (head + 1) % RING_DEPTH;
      fill--;
      if (board_rank(s) == GOAL_RANK) begin
        v.move_count = d;
        v.reachable = 1'b1;
        return v;
      end
      // neighbors in order up, right, down, left
      for (int k = 0; k < 4; k++) begin
        if (k == 0 && p < 3) continue;
        if (k == 1 && p % 3 == 2) continue;
        if (k == 2 && p > 5) continue;
        if (k == 3 && p % 3 == 0) continue;
        q = (k == 0) ? p - 3 : (k == 1) ? p + 1 : (k == 2) ? p + 3 : p - 1;
        n = s;
        n[p] = s[q];
        n[q] = 4'd0;
        r = board_rank(n);
        if (!visited[r]) begin
          visited[r] = 1'b1;
          if (fill < RING_DEPTH) begin
            ring_tiles[tail] = flatten(n);
            ring_blank[tail] = q[3:0];
            ring_depth[tail] = d + 5'd1;
            tail = (tail + 1) % RING_DEPTH;
            fill++;
          end
        end
      end
    end
    return v;
  endfunction

  // goal board with the blank walked a few random legal steps
  function automatic tiles_t scrambled_goal(input int steps);
    tiles_t b;
    int     p;
    int     q;
    int     k;
    for (int i = 0; i < 9; i++) b[i] = 4'(8 - i);
    p = 8;
    for (int s = 0; s < steps; s++) begin
      k = $urandom_range(3);
      if (k == 0 && p < 3) k = 2;
      if (k == 2 && p > 5) k = 0;
      if (k == 1 && p % 3 == 2) k = 3;
      if (k == 3 && p % 3 == 0) k = 1;
      q = (k == 0) ? p - 3 : (k == 1) ? p + 1 : (k == 2) ? p + 3 : p - 1;
      b[p] = b[q];
      b[q] = 4'd0;
      p = q;
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // drive one board and record its expected verdict at acceptance
  task automatic send_board(input tiles_t b);
    verdict_t v;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, flatten(b)};
    v = fewest_moves(b);
    do @(posedge clk); while (!s_axis_tready);
    verdict_q.push_back(v);
    boards_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase(input int send_idle, input int recv_stall);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
  endtask

  task automatic test_solved_and_near();
    tiles_t b;
    set_phase(0, 0);
    send_board(scrambled_goal(0));
    send_board(scrambled_goal(1));
    // goal board with the blank walked four random legal steps
    for (int i = 0; i < 9; i++) b[i] = 4'(8 - i);
    b = scrambled_goal(4);
    send_board(b);
    send_board(scrambled_goal(8));
    send_board(scrambled_goal(12));
  endtask

  task automatic test_bad_boards();
    tiles_t b;
    set_phase(0, 0);
    foreach (b[i]) b[i] = 4'hF;
    send_board(b);
    foreach (b[i]) b[i] = 4'h0;
    send_board(b);
    // tile value just out of range
    b = scrambled_goal(0);
    b[4] = 4'd9;
    send_board(b);
    // repeated tile
    b = scrambled_goal(0);
    b[0] = 4'd7;
    send_board(b);
    // two blanks
    b = scrambled_goal(2);
    b[0] = 4'd0;
    send_board(b);
    for (int i = 0; i < 9; i++) b[i] = 4'(4'hA + i % 6);
    send_board(b);
  endtask

  // swapping two tiles flips the parity and exhausts the search
  task automatic test_wrong_parity();
    tiles_t b;
    set_phase(0, 0);
    b = scrambled_goal(0);
    b[0] = 4'd7;
    b[1] = 4'd8;
    send_board(b);
    drain_results();
  endtask

  task automatic test_random(input int count);
    tiles_t b;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 65) begin
        b = scrambled_goal($urandom_range(0, 10));
      end else begin
        foreach (b[i]) b[i] = 4'($urandom_range(15));
        // in half of these cases only a single tile of a near-goal board is corrupted
        if ($urandom_range(1)) begin
          b = scrambled_goal($urandom_range(0, 4));
          b[$urandom_range(8)] = 4'($urandom_range(15));
        end
      end
      send_board(b);
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = verdict_q.pop_front();
        if (want.bad_input) bad_seen++;
        else if (want.reachable) solved_seen++;
        else parity_seen++;
        if (m_axis_tdata[4:0] != want.move_count)
          report_mismatch("move_count", m_axis_tdata[4:0], want.move_count);
        if (m_axis_tdata[5] != want.reachable)
          report_mismatch("reachable", m_axis_tdata[5], want.reachable);
        if (m_axis_tdata[6] != want.bad_input)
          report_mismatch("bad_input", m_axis_tdata[6], want.bad_input);
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatch_count = 0;
    boards_sent = 0;
    words_checked = 0;
    solved_seen = 0;
    parity_seen = 0;
    bad_seen = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_solved_and_near();
    test_bad_boards();
    test_wrong_parity();
    set_phase(0, 0);
    test_random(20);
    set_phase(64, 0);
    test_random(20);
    set_phase(0, 64);
    test_random(20);
    set_phase(10, 10);
    test_random(20);
    drain_results();
    set_phase(0, 0);
    test_random(10);
    drain_results();
    repeat (50) @(posedge clk);

    $display("Sent %0d boards, checked %0d words: %0d solved, %0d wrong parity, %0d bad.",
             boards_sent, words_checked, solved_seen, parity_seen, bad_seen);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spbfs_pkg.sv
rtl/spbfs_ram.sv
rtl/spbfs_front.sv
rtl/spbfs_jobq.sv
rtl/spbfs_search.sv
rtl/sliding_puzzle_bfs_distance.sv
rtl/spbfs_checker.sv
sim/tb.sv
